// ===== hdl/pol_pkg.sv =====
package pol_pkg;

   localparam int CAPACITY = 16;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int POS_W    = 8;
   localparam int VALUE_W  = 32;

   typedef enum logic [2:0] {
      ACT_APPEND    = 3'd0,
      ACT_PREPEND   = 3'd1,
      ACT_INSERT_AT = 3'd2,
      ACT_DEL_FIRST = 3'd3,
      ACT_DEL_LAST  = 3'd4,
      ACT_DEL_AT    = 3'd5,
      ACT_READ_OUT  = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_EMPTY  = 2'd1,
      STATUS_BADPOS = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_LEFT,
      CELL_FROM_RIGHT,
      CELL_FROM_HEAD
   } cell_cmd_type;

   typedef enum logic {
      STATE_IDLE,
      STATE_READ
   } state_type;

endpackage

// ===== hdl/positional_ordered_list.sv =====
// Ordered list of up to CAPACITY signed 32-bit entries held in a chain of cells, one entry per
// cell, addressed by 1-based position. Append, prepend, insert and the three deletes finish in
// the cycle the request word is accepted: every later cell moves one place toward or away from
// the head at once, and one response word (status and new count) follows from the response
// register. A read-out of n entries gives n response words, one per cycle while rsp_ready is
// high, the last with rsp_last set; they are paced by the chain rotating the occupied cells one
// place per cycle through the head cell, which leaves the list in its original order when done.
// A new request word is taken whenever no read-out is running and the response register is
// empty or being emptied. Errors (empty list, bad position, full list) leave the list
// untouched. The store needs no clearing after reset: only occupied cells are ever read.
module positional_ordered_list
   import pol_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_action,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [COUNT_W-1:0]        rsp_count,
   output logic signed [VALUE_W-1:0] rsp_entry_value,
   output logic                      rsp_last
);

   state_type                 state_ff, state_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [COUNT_W-1:0]        rd_ff, rd_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                      rsp_last_ff, rsp_last_in;

   cell_cmd_type              cell_cmd   [CAPACITY];
   logic signed [VALUE_W-1:0] cell_value [CAPACITY];

   logic                      out_free;
   logic                      req_accept;
   logic                      read_step;
   logic                      read_last;
   logic                      list_empty;
   logic                      list_full;
   logic [POS_W-1:0]          count_pos;
   logic                      do_ins;
   logic                      do_del;
   logic [POS_W-1:0]          idx;

   // The response register may refill in the cycle its word is taken.
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == STATE_IDLE) && out_free;
   assign req_accept = req_valid && req_ready;
   assign read_step  = (state_ff == STATE_READ) && out_free;
   assign read_last  = (rd_ff == count_ff - COUNT_W'(1));
   assign list_empty = (count_ff == '0);
   assign list_full  = (count_ff == COUNT_W'(CAPACITY));
   assign count_pos  = POS_W'(count_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (req_accept && action_type'(req_action) == ACT_READ_OUT && !list_empty) begin
               state_in = STATE_READ;
            end
         end
         STATE_READ: begin
            if (out_free && read_last) begin
               state_in = STATE_IDLE;
            end
         end
         default: state_in = STATE_IDLE;
      endcase
   end

   // Datapath control: decode the action, steer the cells, load the response.
   always_comb begin
      count_in      = count_ff;
      rd_in         = rd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      do_ins        = 1'b0;
      do_del        = 1'b0;
      idx           = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         cell_cmd[i] = CELL_HOLD;
      end

      if (req_accept) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_value_in  = '0;
         rsp_last_in   = 1'b1;
         case (action_type'(req_action))
            ACT_APPEND: begin
               if (list_full) rsp_status_in = STATUS_FULL;
               else begin
                  do_ins = 1'b1;
                  idx    = count_pos;
               end
            end
            ACT_PREPEND: begin
               if (list_full) rsp_status_in = STATUS_FULL;
               else do_ins = 1'b1;
            end
            ACT_INSERT_AT: begin
               // Position is checked before fullness.
               if (req_position == '0 || req_position > count_pos + POS_W'(1)) begin
                  rsp_status_in = STATUS_BADPOS;
               end else if (list_full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  do_ins = 1'b1;
                  idx    = req_position - POS_W'(1);
               end
            end
            ACT_DEL_FIRST: begin
               if (list_empty) rsp_status_in = STATUS_EMPTY;
               else do_del = 1'b1;
            end
            ACT_DEL_LAST: begin
               // Dropping the tail needs no cell movement.
               if (list_empty) rsp_status_in = STATUS_EMPTY;
               else count_in = count_ff - COUNT_W'(1);
            end
            ACT_DEL_AT: begin
               if (list_empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else if (req_position == '0 || req_position > count_pos) begin
                  rsp_status_in = STATUS_BADPOS;
               end else begin
                  do_del = 1'b1;
                  idx    = req_position - POS_W'(1);
               end
            end
            ACT_READ_OUT: begin
               if (list_empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  // Words come from the read state; nothing this cycle.
                  rsp_valid_in = 1'b0;
                  rd_in        = '0;
               end
            end
            default: ;
         endcase

         if (do_ins) count_in = count_ff + COUNT_W'(1);
         if (do_del) count_in = count_ff - COUNT_W'(1);
         rsp_count_in = count_in;

         for (int i = 0; i < CAPACITY; i++) begin
            if (do_ins) begin
               if (POS_W'(i) == idx) begin
                  cell_cmd[i] = CELL_LOAD;
               end else if (POS_W'(i) > idx && POS_W'(i) <= count_pos) begin
                  cell_cmd[i] = CELL_FROM_LEFT;
               end
            end else if (do_del) begin
               if (POS_W'(i) >= idx && POS_W'(i) + POS_W'(1) < count_pos) begin
                  cell_cmd[i] = CELL_FROM_RIGHT;
               end
            end
         end
      end else if (read_step) begin
         // Emit the head and rotate the occupied cells one place.
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_count_in  = count_ff;
         rsp_value_in  = cell_value[0];
         rsp_last_in   = read_last;
         rd_in         = rd_ff + COUNT_W'(1);
         for (int i = 0; i < CAPACITY; i++) begin
            if (COUNT_W'(i) + COUNT_W'(1) < count_ff) begin
               cell_cmd[i] = CELL_FROM_RIGHT;
            end else if (COUNT_W'(i) + COUNT_W'(1) == count_ff) begin
               cell_cmd[i] = CELL_FROM_HEAD;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // The chain: each cell sees both neighbors and the head cell.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VALUE_W-1:0] left_v;
      logic signed [VALUE_W-1:0] right_v;

      if (g == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_inner_l
         assign left_v = cell_value[g-1];
      end

      if (g == CAPACITY - 1) begin : g_final
         assign right_v = '0;
      end else begin : g_inner_r
         assign right_v = cell_value[g+1];
      end

      pol_cell u_cell (
         .clock       (clock),
         .cmd         (cell_cmd[g]),
         .left_value  (left_v),
         .right_value (right_v),
         .head_value  (cell_value[0]),
         .new_value   (req_value),
         .entry_value (cell_value[g])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== hdl/pol_cell.sv =====
module pol_cell
   import pol_pkg::*;
(
   input  logic                      clock,
   input  cell_cmd_type              cmd,
   input  logic signed [VALUE_W-1:0] left_value,
   input  logic signed [VALUE_W-1:0] right_value,
   input  logic signed [VALUE_W-1:0] head_value,
   input  logic signed [VALUE_W-1:0] new_value,
   output logic signed [VALUE_W-1:0] entry_value
);

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;

   always_comb begin
      case (cmd)
         CELL_LOAD:       entry_in = new_value;
         CELL_FROM_LEFT:  entry_in = left_value;
         CELL_FROM_RIGHT: entry_in = right_value;
         CELL_FROM_HEAD:  entry_in = head_value;
         default:         entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_value = entry_ff;

endmodule
